### rtl/core/rli_pkg.sv
// Shared types and constants for the ray against 2D line block.
package rli_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_BEHIND   = 2'd2
    } t_status;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_X = 3'd2;
    localparam logic [2:0] REG_NORMAL_Y = 3'd3;
    localparam logic [2:0] REG_TOL      = 3'd4;

    // Depth of the queue between front and back, and register stages in the front
    localparam int QDEPTH       = 8;
    localparam int FRONT_STAGES = 3;

    // Classification of a ray, decided in the front
    typedef struct packed {
        logic parallel;
        logic opposite;
    } t_cls;

endpackage

### rtl/core/rli_front.sv
// Front: dot products, parallel test and sign classification of each ray.
module rli_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [W-1:0]    i_start_x,
    input  logic signed [W-1:0]    i_start_y,
    input  logic signed [W-1:0]    i_dir_x,
    input  logic signed [W-1:0]    i_dir_y,
    input  logic signed [W-1:0]    i_origin_x,
    input  logic signed [W-1:0]    i_origin_y,
    input  logic signed [W-1:0]    i_normal_x,
    input  logic signed [W-1:0]    i_normal_y,
    input  logic        [W-2:0]    i_tol,
    output logic                   o_valid,
    output rli_pkg::t_cls          o_cls,
    output logic [2*W+F+1:0]       o_num,
    output logic [2*W:0]           o_den,
    output logic signed [W-1:0]    o_start_x,
    output logic signed [W-1:0]    o_start_y,
    output logic signed [W-1:0]    o_dir_x,
    output logic signed [W-1:0]    o_dir_y
);
    import rli_pkg::*;

    logic                  r_v1, r_v2;
    logic signed [W-1:0]   r_sx1, r_sy1, r_dx1, r_dy1;
    logic signed [W-1:0]   r_sx2, r_sy2, r_dx2, r_dy2;
    logic signed [W:0]     r_ex, r_ey;
    logic signed [2*W:0]   r_p0x, r_p0y;
    logic signed [2*W-1:0] r_p1x, r_p1y;
    logic signed [2*W+1:0] l0;
    logic signed [2*W:0]   l1;
    logic        [2*W+1:0] mag0;
    logic        [2*W:0]   mag1;
    logic        [W+F-2:0] tolx;
    t_cls                  n_cls;

    // Sum the products and classify
    assign l0      = r_p0x + r_p0y;
    assign l1      = r_p1x + r_p1y;
    assign mag0    = l0[2*W+1] ? -l0 : l0;
    assign mag1    = l1[2*W] ? -l1 : l1;
    assign tolx    = {i_tol, {F{1'b0}}};
    assign n_cls.parallel = (mag1 <= tolx);
    assign n_cls.opposite = (l0[2*W+1] != l1[2*W]);

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    // Differences, products, then sums
    always_ff @(posedge i_clk) begin
        r_sx1 <= i_start_x;
        r_sy1 <= i_start_y;
        r_dx1 <= i_dir_x;
        r_dy1 <= i_dir_y;
        r_ex  <= {i_origin_x[W-1], i_origin_x} - {i_start_x[W-1], i_start_x};
        r_ey  <= {i_origin_y[W-1], i_origin_y} - {i_start_y[W-1], i_start_y};

        r_sx2 <= r_sx1;
        r_sy2 <= r_sy1;
        r_dx2 <= r_dx1;
        r_dy2 <= r_dy1;
        r_p0x <= r_ex * i_normal_x;
        r_p0y <= r_ey * i_normal_y;
        r_p1x <= r_dx1 * i_normal_x;
        r_p1y <= r_dy1 * i_normal_y;

        o_cls     <= n_cls;
        o_num     <= {mag0, {F{1'b0}}};
        o_den     <= mag1;
        o_start_x <= r_sx2;
        o_start_y <= r_sy2;
        o_dir_x   <= r_dx2;
        o_dir_y   <= r_dy2;
    end

endmodule

### rtl/core/rli_queue.sv
// Queue between front and back: memory FIFO with registered read data.
module rli_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import rli_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             pop;

    // Pop whenever something waits: the back never stalls
    assign pop     = (r_count != '0);
    assign n_count = r_count + CW'(i_push) - CW'(pop);
    assign o_count = r_count;

    // Pointers, occupancy and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (pop)    r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            r_count <= n_count;
            o_valid <= pop;
        end
    end

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
        if (pop)    o_data      <= r_mem[r_rd];
    end

endmodule

### rtl/core/rli_back.sv
// Back: pipelined restoring divider, hit point products, clamping.
module rli_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rli_pkg::t_cls          i_cls,
    input  logic [2*W+F+1:0]       i_num,
    input  logic [2*W:0]           i_den,
    input  logic signed [W-1:0]    i_start_x,
    input  logic signed [W-1:0]    i_start_y,
    input  logic signed [W-1:0]    i_dir_x,
    input  logic signed [W-1:0]    i_dir_y,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [W-2:0]           o_distance,
    output logic signed [W-1:0]    o_hit_x,
    output logic signed [W-1:0]    o_hit_y,
    output logic                   o_saturated
);
    import rli_pkg::*;

    // Quotient bits kept; larger quotients clamp to 2^QB
    localparam int QB = W + F + 1;
    localparam int HL = (QB + 1) / 2;
    localparam int HH = QB + 1 - HL;
    localparam int PW = 2*W + F + 3;
    localparam int SW = PW - F;

    localparam logic [QB-1:0] DMAX = {{(F+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QB:0]   QSAT = {1'b1, {QB{1'b0}}};
    localparam logic signed [SW:0] HMAX = {{(W+5){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW:0] HMIN = {{(W+5){1'b1}}, {(W-1){1'b0}}};

    // Divider stage registers, one set per quotient bit
    logic                 r_dv   [QB+1];
    logic [2*W:0]         r_rem  [QB+1];
    logic [2*W:0]         r_den  [QB+1];
    logic [QB-1:0]        r_low  [QB+1];
    logic [QB-1:0]        r_q    [QB+1];
    logic                 r_ovf  [QB+1];
    t_cls                 r_cls  [QB+1];
    logic signed [W-1:0]  r_sx   [QB+1];
    logic signed [W-1:0]  r_sy   [QB+1];
    logic signed [W-1:0]  r_dx   [QB+1];
    logic signed [W-1:0]  r_dy   [QB+1];

    logic [W:0]           top;

    // Seed the divider; flag quotients of 2^QB or more
    assign top = i_num[2*W+F+1:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else          r_dv[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_ovf[0] <= ({{W{1'b0}}, top} >= i_den);
        r_rem[0] <= {{W{1'b0}}, top};
        r_den[0] <= i_den;
        r_low[0] <= i_num[QB-1:0];
        r_q[0]   <= '0;
        r_cls[0] <= i_cls;
        r_sx[0]  <= i_start_x;
        r_sy[0]  <= i_start_y;
        r_dx[0]  <= i_dir_x;
        r_dy[0]  <= i_dir_y;
    end

    // One quotient bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [2*W+1:0] shifted;
        logic [2*W+1:0] diff;
        logic           ge;

        assign shifted = {r_rem[k], r_low[k][QB-1-k]};
        assign ge      = (shifted >= {1'b0, r_den[k]});
        assign diff    = shifted - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[k+1] <= 1'b0;
            else          r_dv[k+1] <= r_dv[k];
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff[2*W:0] : shifted[2*W:0];
            r_q[k+1]   <= {r_q[k][QB-2:0], ge};
            r_den[k+1] <= r_den[k];
            r_low[k+1] <= r_low[k];
            r_ovf[k+1] <= r_ovf[k];
            r_cls[k+1] <= r_cls[k];
            r_sx[k+1]  <= r_sx[k];
            r_sy[k+1]  <= r_sy[k];
            r_dx[k+1]  <= r_dx[k];
            r_dy[k+1]  <= r_dy[k];
        end
    end

    // Quotient checks and split products
    logic [QB-1:0]         q;
    logic [QB:0]           qs;
    logic                  ovf;
    t_status               n_status;
    logic                  r_m0_v, r_m1_v;
    t_status               r_m0_st, r_m1_st;
    logic [W-2:0]          r_m0_dist, r_m1_dist;
    logic                  r_m0_dsat, r_m1_dsat;
    logic signed [W-1:0]   r_m0_sx, r_m0_sy, r_m1_sx, r_m1_sy;
    logic signed [HL+W:0]  r_pxl, r_pyl;
    logic signed [HH+W:0]  r_pxh, r_pyh;

    assign q   = r_q[QB];
    assign ovf = r_ovf[QB];
    assign qs  = ovf ? QSAT : {1'b0, q};

    always_comb begin
        if (r_cls[QB].parallel)                            n_status = ST_PARALLEL;
        else if (r_cls[QB].opposite || (!ovf && q == '0))  n_status = ST_BEHIND;
        else                                               n_status = ST_HIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_v  <= 1'b0;
            r_m1_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_m0_v  <= r_dv[QB];
            r_m1_v  <= r_m0_v;
            o_valid <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m0_st   <= n_status;
        r_m0_dsat <= ovf || (q > DMAX);
        r_m0_dist <= (ovf || (q > DMAX)) ? DMAX[W-2:0] : q[W-2:0];
        r_m0_sx   <= r_sx[QB];
        r_m0_sy   <= r_sy[QB];
        r_pxl     <= $signed({1'b0, qs[HL-1:0]}) * r_dx[QB];
        r_pyl     <= $signed({1'b0, qs[HL-1:0]}) * r_dy[QB];
        r_pxh     <= $signed({1'b0, qs[QB:HL]}) * r_dx[QB];
        r_pyh     <= $signed({1'b0, qs[QB:HL]}) * r_dy[QB];
    end

    // Join the partial products and drop the fraction
    logic signed [PW-1:0] ext_xh, ext_yh, sum_x, sum_y;
    logic signed [SW-1:0] r_shx, r_shy;

    assign ext_xh = r_pxh;
    assign ext_yh = r_pyh;
    assign sum_x  = (ext_xh <<< HL) + r_pxl;
    assign sum_y  = (ext_yh <<< HL) + r_pyl;

    always_ff @(posedge i_clk) begin
        r_shx     <= sum_x[PW-1:F];
        r_shy     <= sum_y[PW-1:F];
        r_m1_st   <= r_m0_st;
        r_m1_dist <= r_m0_dist;
        r_m1_dsat <= r_m0_dsat;
        r_m1_sx   <= r_m0_sx;
        r_m1_sy   <= r_m0_sy;
    end

    // Add the start point, clamp, zero the non-hit results
    logic signed [SW:0] hx, hy;
    logic               sx_hi, sx_lo, sy_hi, sy_lo, hit;

    assign hx    = r_m1_sx + r_shx;
    assign hy    = r_m1_sy + r_shy;
    assign sx_hi = (hx > HMAX);
    assign sx_lo = (hx < HMIN);
    assign sy_hi = (hy > HMAX);
    assign sy_lo = (hy < HMIN);
    assign hit   = (r_m1_st == ST_HIT);

    always_ff @(posedge i_clk) begin
        o_status    <= r_m1_st;
        o_distance  <= hit ? r_m1_dist : '0;
        o_hit_x     <= !hit ? '0 : sx_hi ? HMAX[W-1:0] : sx_lo ? HMIN[W-1:0] : hx[W-1:0];
        o_hit_y     <= !hit ? '0 : sy_hi ? HMAX[W-1:0] : sy_lo ? HMIN[W-1:0] : hy[W-1:0];
        o_saturated <= hit && (r_m1_dsat || sx_hi || sx_lo || sy_hi || sy_lo);
    end

endmodule

### rtl/core/ray_line_intersection_2d.sv
// Ray against a configured 2D line: each ray passes the front, the queue and the back
// on its way from start to the result strobe.
// One ray per cycle while not busy: the divider is pipelined, one quotient bit per stage.
// start is refused (busy) only while the front-to-back queue is nearly full.
// Synchronous active-low reset clears the pipeline and restores register defaults.
// Results are strobed for one cycle; the receiver cannot stall them.
module ray_line_intersection_2d #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int DW = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int AS = (COORD_WIDTH > 32) ? 3 : 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [AS+2:0]                 paddr,
    input  logic [DW-1:0]                 pwdata,
    output logic [DW-1:0]                 prdata,
    output logic                          pready,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [COORD_WIDTH-2:0]        o_distance,
    output logic signed [COORD_WIDTH-1:0] o_hit_x,
    output logic signed [COORD_WIDTH-1:0] o_hit_y,
    output logic                          o_saturated
);
    import rli_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2*W + F + 2;
    localparam int QW = 2 + NW + (2*W + 1) + 4*W;
    localparam int CW = $clog2(QDEPTH+1);

    logic signed [W-1:0] r_origin_x, r_origin_y, r_normal_x, r_normal_y;
    logic        [W-2:0] r_tol;
    logic        [2:0]   idx;
    logic                wr;

    // Configuration registers
    assign pready = 1'b1;
    assign idx    = paddr[AS+2:AS];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_normal_x <= {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
            r_normal_y <= '0;
            r_tol      <= '0;
        end else if (wr) begin
            case (idx)
                REG_ORIGIN_X: r_origin_x <= pwdata[W-1:0];
                REG_ORIGIN_Y: r_origin_y <= pwdata[W-1:0];
                REG_NORMAL_X: r_normal_x <= pwdata[W-1:0];
                REG_NORMAL_Y: r_normal_y <= pwdata[W-1:0];
                REG_TOL:      r_tol      <= pwdata[W-2:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (idx)
            REG_ORIGIN_X: prdata = DW'(unsigned'(r_origin_x));
            REG_ORIGIN_Y: prdata = DW'(unsigned'(r_origin_y));
            REG_NORMAL_X: prdata = DW'(unsigned'(r_normal_x));
            REG_NORMAL_Y: prdata = DW'(unsigned'(r_normal_y));
            REG_TOL:      prdata = DW'(r_tol);
            default:      prdata = '0;
        endcase
    end

    // Front: classify each transaction
    logic                f_valid;
    t_cls                f_cls;
    logic [NW-1:0]       f_num;
    logic [2*W:0]        f_den;
    logic signed [W-1:0] f_sx, f_sy, f_dx, f_dy;
    logic [CW-1:0]       q_count;

    assign o_busy = (q_count >= CW'(QDEPTH - FRONT_STAGES));

    rli_front #(.W(W), .F(F)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_start && !o_busy),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .i_normal_x (r_normal_x),
        .i_normal_y (r_normal_y),
        .i_tol      (r_tol),
        .o_valid    (f_valid),
        .o_cls      (f_cls),
        .o_num      (f_num),
        .o_den      (f_den),
        .o_start_x  (f_sx),
        .o_start_y  (f_sy),
        .o_dir_x    (f_dx),
        .o_dir_y    (f_dy)
    );

    // Queue between front and back
    logic          b_valid;
    logic [QW-1:0] b_data;

    rli_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_cls, f_num, f_den, f_sx, f_sy, f_dx, f_dy}),
        .o_valid (b_valid),
        .o_data  (b_data),
        .o_count (q_count)
    );

    // Back: divide, form the hit point, clamp
    t_cls                b_cls;
    logic [NW-1:0]       b_num;
    logic [2*W:0]        b_den;
    logic signed [W-1:0] b_sx, b_sy, b_dx, b_dy;

    assign {b_cls, b_num, b_den, b_sx, b_sy, b_dx, b_dy} = b_data;

    rli_back #(.W(W), .F(F)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (b_valid),
        .i_cls       (b_cls),
        .i_num       (b_num),
        .i_den       (b_den),
        .i_start_x   (b_sx),
        .i_start_y   (b_sy),
        .i_dir_x     (b_dx),
        .i_dir_y     (b_dy),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_distance  (o_distance),
        .o_hit_x     (o_hit_x),
        .o_hit_y     (o_hit_y),
        .o_saturated (o_saturated)
    );

endmodule

### verif/ray_line_intersection_2d_tb.sv
// Self-checking testbench for the ray against 2D line intersection block.
`timescale 1ns / 1ps

module ray_line_intersection_2d_tb;
    import rli_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = CW + FB + 10;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        t_status          status;
        logic [CW-2:0]    distance;
        logic [CW-1:0]    hit_x;
        logic [CW-1:0]    hit_y;
        logic             saturated;
    } t_hit_result;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [4:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;
    logic            i_start = 1'b0;
    logic            o_busy;
    logic [CW-1:0]   i_start_x = '0;
    logic [CW-1:0]   i_start_y = '0;
    logic [CW-1:0]   i_dir_x = '0;
    logic [CW-1:0]   i_dir_y = '0;
    logic            o_valid;
    logic [1:0]      o_status;
    logic [CW-2:0]   o_distance;
    logic [CW-1:0]   o_hit_x;
    logic [CW-1:0]   o_hit_y;
    logic            o_saturated;

    // Local copy of the line registers
    logic signed [CW-1:0] line_ox = '0;
    logic signed [CW-1:0] line_oy = '0;
    logic signed [CW-1:0] line_nx = 32'sd65536;
    logic signed [CW-1:0] line_ny = '0;
    logic [CW-2:0]        line_tol = '0;

    t_hit_result pending_hits[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  allow_gaps = 1'b1;

    ray_line_intersection_2d uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_start(i_start), .o_busy(o_busy),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y),
        .o_valid(o_valid), .o_status(o_status), .o_distance(o_distance),
        .o_hit_x(o_hit_x), .o_hit_y(o_hit_y), .o_saturated(o_saturated)
    );

    always #1 i_clk = ~i_clk;

    // Work out the result of one ray against the current line, exactly
    function automatic t_hit_result intersect_ray(logic signed [CW-1:0] sx,
            logic signed [CW-1:0] sy, logic signed [CW-1:0] dx,
            logic signed [CW-1:0] dy);
        t_hit_result r;
        logic signed [255:0] l0, l1, tol, s, hx, hy, a0, a1, q;
        logic signed [255:0] cmax, cmin;
        r.status = ST_HIT;
        r.distance = '0;
        r.hit_x = '0;
        r.hit_y = '0;
        r.saturated = 1'b0;
        l0 = (256'(line_ox) - 256'(sx)) * 256'(line_nx)
           + (256'(line_oy) - 256'(sy)) * 256'(line_ny);
        l1 = 256'(dx) * 256'(line_nx) + 256'(dy) * 256'(line_ny);
        tol = $signed({225'd0, line_tol}) <<< FB;
        a1 = (l1 < 0) ? -l1 : l1;
        if (a1 <= tol) begin
            r.status = ST_PARALLEL;
            return r;
        end
        a0 = l0 <<< FB;
        if (a0 < 0) a0 = -a0;
        q = $signed($unsigned(a0) / $unsigned(a1));
        s = ((l0 < 0) != (l1 < 0)) ? -q : q;
        if (s <= 0) begin
            r.status = ST_BEHIND;
            return r;
        end
        cmax = 256'sd2147483647;
        cmin = -256'sd2147483648;
        hx = 256'(sx) + ((s * 256'(dx)) >>> FB);
        hy = 256'(sy) + ((s * 256'(dy)) >>> FB);
        if (hx > cmax) begin hx = cmax; r.saturated = 1'b1; end
        if (hx < cmin) begin hx = cmin; r.saturated = 1'b1; end
        if (hy > cmax) begin hy = cmax; r.saturated = 1'b1; end
        if (hy < cmin) begin hy = cmin; r.saturated = 1'b1; end
        if (s > cmax) begin s = cmax; r.saturated = 1'b1; end
        r.distance = s[CW-2:0];
        r.hit_x = hx[CW-1:0];
        r.hit_y = hy[CW-1:0];
        return r;
    endfunction

    // Compare each strobed result with the oldest pending one
    always @(posedge i_clk) begin
        t_hit_result e;
        if (i_rst_n && o_valid) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, o_status);
                fail_count++;
            end else begin
                e = pending_hits.pop_front();
                if (o_status !== e.status || o_distance !== e.distance ||
                        o_hit_x !== e.hit_x || o_hit_y !== e.hit_y ||
                        o_saturated !== e.saturated) begin
                    $display("%0t: expected st=%0d d=%h x=%h y=%h sat=%b", $time,
                             e.status, e.distance, e.hit_x, e.hit_y, e.saturated);
                    $display("%0t: actual   st=%0d d=%h x=%h y=%h sat=%b", $time,
                             o_status, o_distance, o_hit_x, o_hit_y, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Now and then, while gaps are allowed, drop start for a random burst of idle cycles
    task automatic idle_burst();
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Send one ray and hold start until it is taken
    task automatic send_ray(logic [CW-1:0] sx, logic [CW-1:0] sy,
                            logic [CW-1:0] dx, logic [CW-1:0] dy);
        i_start <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_dir_x <= dx;
        i_dir_y <= dy;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_hits.push_back(intersect_ray(sx, sy, dx, dy));
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every pending result has come, then let the pipe drain
    task automatic drain_results();
        stop_sending();
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ORIGIN_X: line_ox = value;
            REG_ORIGIN_Y: line_oy = value;
            REG_NORMAL_X: line_nx = value;
            REG_NORMAL_Y: line_ny = value;
            REG_TOL:      line_tol = value[CW-2:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_line(logic [31:0] ox, logic [31:0] oy, logic [31:0] nx,
                            logic [31:0] ny, logic [31:0] tol);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_TOL, tol);
    endtask

    // Small Q16.16 values half the time, else full range or near the extremes
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFFFFFF - $urandom_range(0, 3);
            2: return 32'h80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
        endcase
    endfunction

    // Extremes, parallel, behind, at-start, sub-LSB, tolerance and clamping cases
    task automatic test_directed();
        set_line('0, '0, 32'h00010000, '0, '0);
        send_ray(32'hFFFF0000, '0, 32'h00010000, '0);   // hit at s = 1
        send_ray(32'h00010000, '0, 32'h00010000, '0);   // line behind
        send_ray('0, 32'h00050000, 32'h00010000, '0);   // starts on line
        send_ray(32'hFFFF0000, '0, '0, 32'h00010000);   // exactly parallel
        send_ray(32'hFFFF0000, '0, '0, '0);             // zero direction
        send_ray(32'h80000000, 32'h80000000, 32'h00000001, 32'h7FFFFFFF); // clamp
        send_ray(32'h80000000, '0, 32'h7FFFFFFF, 32'h80000000);
        send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
        send_ray(32'hFFFFFFFF, '0, 32'h7FFFFFFF, '0);   // ratio below one LSB
        send_ray(32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
        drain_results();
        set_line(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_ray('0, '0, 32'h00010000, 32'h00010000);   // all within tolerance
        send_ray(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        drain_results();
        set_line(32'h00020000, 32'hFFFE0000, 32'h0000B505, 32'h0000B505, 32'h00000100);
        send_ray('0, '0, 32'h00000001, 32'h00000001);   // well inside tolerance
        send_ray('0, '0, 32'h00010000, 32'h00010000);
        send_ray('0, '0, 32'hFFFF0000, 32'h00000000);
        send_ray(32'h12345678, 32'h87654321, 32'hFFFFFFFF, 32'h00000000);
        drain_results();
    endtask

    // Random rays against a range of line settings
    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 7) allow_gaps = 1'b0;
            set_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     (phase % 3 == 0) ? 32'd0 : {1'b0, 31'($urandom_range(0, 32'hFFFF))});
            for (int n = 0; n < 50; n++) begin
                idle_burst();
                send_ray(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
            drain_results();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
